// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL of the bit field packer.
// Bodies collapse to nothing when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define BFP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");
`define BFP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`else
`define BFP_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define BFP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/core/bfp_pkg.sv =====
// Package of the bit field packer: widths, opcodes, controller states and
// the command and status records between controller and datapath. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package bfp_pkg;

	localparam int BUF_BYTES_DEF  = 256;
	localparam int VALUE_BITS_DEF = 64;

	localparam int OP_W      = 3;
	localparam int VAL_W     = 64;
	localparam int NBITS_W   = 7;
	localparam int BYTE_W    = 8;
	localparam int POS_W     = 12;
	localparam int WIN_BYTES = 9;
	localparam int WIN_W     = WIN_BYTES * BYTE_W;
	localparam int IDX_W     = 4;
	localparam int IN_DATA_W  = 104;
	localparam int OUT_DATA_W = 88;

	typedef enum logic [OP_W-1:0] {
		OP_PUT   = 3'd0,
		OP_GET   = 3'd1,
		OP_WBYTE = 3'd2,
		OP_RBYTE = 3'd3,
		OP_SEEK  = 3'd4,
		OP_SET   = 3'd5
	} bfp_op_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC,
		ST_MOVE,
		ST_FINISH
	} bfp_state_t;

	typedef struct packed {
		logic load;
		logic clr;
		logic rd_first;
		logic move;
		logic commit;
	} bfp_cmd_t;

	typedef struct packed {
		logic clr_done;
		logic mem_op;
		logic last_byte;
		logic out_free;
	} bfp_sts_t;

endpackage
`default_nettype wire

// ===== rtl/core/bfp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module bfp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/bfp_ctrl.sv =====
// Controller state machine of the bit field packer: clearing pass,
// request intake, byte sequencing and result hand-off. Uses bfp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bfp_ctrl
	import bfp_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     s_tvalid,
	output logic          s_tready,
	input  wire bfp_sts_t sts,
	output bfp_cmd_t      cmd
);

	bfp_state_t state_q;
	bfp_state_t state_d;

	// State register; reset starts the buffer clearing pass.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr = 1'b1;
				if (sts.clr_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (sts.mem_op) begin
					cmd.rd_first = 1'b1;
					state_d      = ST_MOVE;
				end else begin
					state_d = ST_FINISH;
				end
			end
			ST_MOVE: begin
				cmd.move = 1'b1;
				if (sts.last_byte) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== rtl/core/bfp_dp.sv =====
// Datapath of the bit field packer: request decode, cursor, byte window,
// merge logic, result register and the buffer RAM. Uses bfp_pkg and bfp_ram.
`timescale 1ns / 1ps
`default_nettype none
module bfp_dp
	import bfp_pkg::*;
#(
	parameter int BUF_BYTES  = BUF_BYTES_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic [IN_DATA_W-1:0]  s_tdata,
	input  wire logic [OP_W-1:0]       s_tuser,
	input  wire logic                  m_tready,
	output logic                       m_tvalid,
	output logic      [OUT_DATA_W-1:0] m_tdata,
	input  wire bfp_cmd_t              cmd,
	output bfp_sts_t                   sts
);

	localparam int AW    = $clog2(BUF_BYTES);
	localparam int CW    = $clog2(BUF_BYTES * 8 + 1);
	localparam int LIMIT = BUF_BYTES * 8;

	// Request fields.
	logic [VAL_W-1:0]   fval;
	logic [NBITS_W-1:0] nbits;
	logic               sext;
	logic [BYTE_W-1:0]  baddr;
	logic [BYTE_W-1:0]  bin;
	logic [POS_W-1:0]   target;

	assign fval   = s_tdata[63:0];
	assign nbits  = s_tdata[70:64];
	assign sext   = s_tdata[71];
	assign baddr  = s_tdata[79:72];
	assign bin    = s_tdata[87:80];
	assign target = s_tdata[99:88];

	// Architectural cursor and operation context.
	logic [CW-1:0]      cursor_q;
	logic [CW-1:0]      cur_next_q;
	logic               mem_q;
	logic               wr_q;
	logic               get_q;
	logic               rbyte_q;
	logic               ovr_q;
	logic               sext_q;
	logic [NBITS_W-1:0] n_q;
	logic [VAL_W-1:0]   lm_q;
	logic [2:0]         sh_q;
	logic [AW-1:0]      addr_q;
	logic [IDX_W-1:0]   cnt_q;
	logic [IDX_W-1:0]   idx_q;
	logic [WIN_W-1:0]   data_q;
	logic [WIN_W-1:0]   mask_q;
	logic [WIN_W-1:0]   win_q;
	logic [AW-1:0]      clr_q;
	logic               out_valid_q;
	logic [OUT_DATA_W-1:0] out_q;

	// Decoded request.
	logic [CW-1:0]      cur_next_d;
	logic               mem_d;
	logic               wr_d;
	logic               get_d;
	logic               rbyte_d;
	logic               ovr_d;
	logic [VAL_W-1:0]   lm_d;
	logic [2:0]         sh_d;
	logic [AW-1:0]      addr_d;
	logic [IDX_W-1:0]   cnt_d;
	logic [WIN_W-1:0]   data_d;
	logic [WIN_W-1:0]   mask_d;
	logic               fits;
	logic               addr_ok;
	logic               pos_ok;
	logic [IDX_W-1:0]   field_bytes;

	// Range checks and per-field geometry at the current cursor.
	always_comb begin
		lm_d        = (64'd1 << nbits) - 64'd1;
		fits        = (nbits != '0) && (32'(nbits) <= VALUE_BITS)
			&& ((32'(cursor_q) + 32'(nbits)) <= LIMIT);
		addr_ok     = 32'(baddr) < BUF_BYTES;
		pos_ok      = 32'(target) <= LIMIT;
		field_bytes = IDX_W'((8'(cursor_q[2:0]) + 8'(nbits) + 8'd7) >> 3);
	end

	// Operation decode.
	always_comb begin
		cur_next_d = cursor_q;
		mem_d      = 1'b0;
		wr_d       = 1'b0;
		get_d      = 1'b0;
		rbyte_d    = 1'b0;
		ovr_d      = 1'b0;
		sh_d       = cursor_q[2:0];
		addr_d     = AW'(cursor_q >> 3);
		cnt_d      = field_bytes;
		data_d     = {8'h00, fval & lm_d} << cursor_q[2:0];
		mask_d     = {8'h00, lm_d} << cursor_q[2:0];
		case (bfp_op_t'(s_tuser))
			OP_PUT: begin
				if (fits) begin
					mem_d      = 1'b1;
					wr_d       = 1'b1;
					cur_next_d = cursor_q + CW'(nbits);
				end else begin
					ovr_d = 1'b1;
				end
			end
			OP_GET: begin
				if (fits) begin
					mem_d      = 1'b1;
					get_d      = 1'b1;
					cur_next_d = cursor_q + CW'(nbits);
				end else begin
					ovr_d = 1'b1;
				end
			end
			OP_WBYTE, OP_RBYTE: begin
				sh_d   = 3'd0;
				addr_d = AW'(baddr);
				cnt_d  = IDX_W'(1);
				data_d = WIN_W'(bin);
				mask_d = WIN_W'(8'hff);
				if (addr_ok) begin
					mem_d   = 1'b1;
					wr_d    = (bfp_op_t'(s_tuser) == OP_WBYTE);
					rbyte_d = (bfp_op_t'(s_tuser) == OP_RBYTE);
				end else begin
					ovr_d = 1'b1;
				end
			end
			OP_SEEK: begin
				if (!pos_ok) begin
					ovr_d = 1'b1;
				end else if (32'(target) > 32'(cursor_q)) begin
					cur_next_d = CW'(target);
				end
			end
			OP_SET: begin
				if (pos_ok) begin
					cur_next_d = CW'(target);
				end else begin
					ovr_d = 1'b1;
				end
			end
			default: begin
				cur_next_d = cursor_q;
			end
		endcase
	end

	// Buffer RAM and its port steering.
	logic              ram_wr_en;
	logic [AW-1:0]     ram_wr_addr;
	logic [BYTE_W-1:0] ram_wr_data;
	logic              ram_rd_en;
	logic [AW-1:0]     ram_rd_addr;
	logic [BYTE_W-1:0] ram_rd_data;
	logic              last_byte;

	assign last_byte   = (cnt_q == IDX_W'(1));
	assign ram_wr_en   = cmd.clr || (cmd.move && wr_q);
	assign ram_wr_addr = cmd.clr ? clr_q : addr_q;
	assign ram_wr_data = cmd.clr ? '0
		: ((ram_rd_data & ~mask_q[BYTE_W-1:0]) | data_q[BYTE_W-1:0]);
	assign ram_rd_en   = cmd.rd_first || (cmd.move && !last_byte);
	assign ram_rd_addr = cmd.rd_first ? addr_q : (addr_q + AW'(1));

	bfp_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(BUF_BYTES)
	) u_ram (
		.clk    (clk),
		.wr_en  (ram_wr_en),
		.wr_addr(ram_wr_addr),
		.wr_data(ram_wr_data),
		.rd_en  (ram_rd_en),
		.rd_addr(ram_rd_addr),
		.rd_data(ram_rd_data)
	);

	// Result assembly from the gathered byte window.
	logic [WIN_W-1:0] aligned;
	logic [VAL_W-1:0] fld;
	logic             sgn;
	logic [VAL_W-1:0] vout;
	logic [BYTE_W-1:0] bout;

	always_comb begin
		aligned = win_q >> sh_q;
		fld     = aligned[VAL_W-1:0] & lm_q;
		sgn     = fld[6'(n_q - 7'd1)];
		vout    = '0;
		if (get_q) begin
			vout = (sext_q && (n_q != 7'(VAL_W)) && sgn) ? (fld | ~lm_q) : fld;
		end
		bout = rbyte_q ? win_q[BYTE_W-1:0] : '0;
	end

	// Control registers: cursor, clear counter, output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q    <= '0;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clr) begin
				clr_q <= clr_q + AW'(1);
			end
			if (cmd.commit) begin
				cursor_q    <= cur_next_q;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Operation context, byte window and result payload.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cur_next_q <= cur_next_d;
			mem_q      <= mem_d;
			wr_q       <= wr_d;
			get_q      <= get_d;
			rbyte_q    <= rbyte_d;
			ovr_q      <= ovr_d;
			sext_q     <= sext;
			n_q        <= nbits;
			lm_q       <= lm_d;
			sh_q       <= sh_d;
			addr_q     <= addr_d;
			cnt_q      <= cnt_d;
			idx_q      <= '0;
			data_q     <= data_d;
			mask_q     <= mask_d;
			win_q      <= '0;
		end else if (cmd.move) begin
			win_q[{idx_q, 3'b000} +: BYTE_W] <= ram_rd_data;
			idx_q  <= idx_q + IDX_W'(1);
			addr_q <= addr_q + AW'(1);
			cnt_q  <= cnt_q - IDX_W'(1);
			data_q <= data_q >> BYTE_W;
			mask_q <= mask_q >> BYTE_W;
		end
		if (cmd.commit) begin
			out_q <= {3'b000, ovr_q, 12'(cur_next_q), bout, vout};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

	assign sts.clr_done  = (clr_q == AW'(BUF_BYTES - 1));
	assign sts.mem_op    = mem_q;
	assign sts.last_byte = last_byte;
	assign sts.out_free  = !out_valid_q || m_tready;

endmodule
`default_nettype wire

// ===== rtl/core/bit_field_pack_unpack.sv =====
// Sequence: a request is taken in idle and decoded; a put or get touching k bytes (1..9)
// or a byte read/write (one byte) then moves through its bytes, one buffer RAM access per
// byte touched; seek, set and refused requests skip the buffer. The result is committed
// once the output register is free. A new request is taken only after that commit.
// Reset: cursor goes to zero, then a clearing pass writes zero to all BUF_BYTES bytes,
// one per cycle, with s_tready low; requests are taken after that.
// Top level of the bit field packer; uses bfp_pkg, bfp_ctrl, bfp_dp, assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module bit_field_pack_unpack
	import bfp_pkg::*;
#(
	parameter int BUF_BYTES  = BUF_BYTES_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	// [63:0] field_value, [70:64] field_bits, [71] sign_extend, [79:72] byte_addr,
	// [87:80] byte_in, [99:88] bit_position, [103:100] zero
	input  wire logic [IN_DATA_W-1:0]  s_tdata,
	// [2:0] opcode
	input  wire logic [OP_W-1:0]       s_tuser,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	// [63:0] value_out, [71:64] byte_out, [83:72] cursor_out, [84] overrun, [87:85] zero
	output logic      [OUT_DATA_W-1:0] m_tdata
);

	bfp_cmd_t cmd;
	bfp_sts_t sts;

	// Sequencer.
	bfp_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	// Decode, buffer and result path.
	bfp_dp #(
		.BUF_BYTES (BUF_BYTES),
		.VALUE_BITS(VALUE_BITS)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tready(m_tready),
		.m_tvalid(m_tvalid),
		.m_tdata (m_tdata),
		.cmd     (cmd),
		.sts     (sts)
	);

	// One request at a time: intake closes right after a request is taken.
	`BFP_ASSERT_NEXT(a_one_at_a_time, clk, arst_n, s_tvalid && s_tready, !s_tready)
	// A result is only committed when the output register can take it.
	`BFP_ASSERT_SAME(a_commit_free, clk, arst_n, cmd.commit, sts.out_free)
	// Byte sequencing only runs for requests that reach the buffer.
	`BFP_ASSERT_SAME(a_move_mem, clk, arst_n, cmd.move, sts.mem_op)
	// A committed result is presented on the next cycle.
	`BFP_ASSERT_NEXT(a_commit_shows, clk, arst_n, cmd.commit, m_tvalid)

endmodule
`default_nettype wire
